### rtl/core/qdv_pkg.sv
// qdv_pkg: widths, step codes and stage payload types for the quadrature
// decoder with velocity. No dependencies; used by every other file.
package qdv_pkg;

	localparam int COUNT_BITS   = 32;
	localparam int SPEED_BITS   = 16;
	localparam int SCALE_BITS   = 16;
	localparam int PROD_BITS    = COUNT_BITS + SCALE_BITS;
	localparam int POS_OUT_BITS = 32;
	localparam int VEL_OUT_BITS = 16;

	localparam logic [SCALE_BITS-1:0] SCALE_RESET = 16'd11932;

	// input action codes
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_TICK   = 1'b1;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	// x4 decode of {previous A, previous B, new A, new B}
	function automatic dir_t step_dir(input logic [3:0] code);
		dir_t d;
		case (code)
			4'b1101, 4'b0100, 4'b0010, 4'b1011: d = DIR_UP;
			4'b1110, 4'b0111, 4'b0001, 4'b1000: d = DIR_DOWN;
			default:                            d = DIR_NONE;
		endcase
		return d;
	endfunction

	// count change since last tick, with the new position
	typedef struct packed {
		logic                  tick;
		logic [COUNT_BITS-1:0] diff;
		logic [COUNT_BITS-1:0] pos;
	} qdv_delta_t;

	// sign and magnitude of the change
	typedef struct packed {
		logic                  tick;
		logic                  neg;
		logic [COUNT_BITS-1:0] mag;
		logic [COUNT_BITS-1:0] pos;
	} qdv_mag_t;

	// scaled magnitude
	typedef struct packed {
		logic                  tick;
		logic                  neg;
		logic [PROD_BITS-1:0]  prod;
		logic [COUNT_BITS-1:0] pos;
	} qdv_prod_t;

endpackage

### rtl/core/qdv_if.sv
// qdv_if: valid/ready channel interfaces for phase samples and results.
// Depends on qdv_pkg for the output widths.
interface qdv_sample_if;
	logic valid;
	logic ready;
	logic action;
	logic phase_a;
	logic phase_b;

	modport source (output valid, output action, output phase_a, output phase_b,
		input ready);
	modport sink (input valid, input action, input phase_a, input phase_b,
		output ready);
endinterface

interface qdv_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [qdv_pkg::VEL_OUT_BITS-1:0] velocity_mm_s;
	logic signed [qdv_pkg::POS_OUT_BITS-1:0] position_count;

	modport source (output valid, output velocity_mm_s, output position_count,
		input ready);
	modport sink (input valid, input velocity_mm_s, input position_count,
		output ready);
endinterface

### rtl/core/qdv_decode.sv
// qdv_decode: input register, x4 phase decode and position state.
// Depends on qdv_pkg.
module qdv_decode
	import qdv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       take,
	input  logic       action,
	input  logic       phase_a,
	input  logic       phase_b,
	output logic       valid_s2,
	output qdv_delta_t delta_s2
);

	logic                  valid_s1;
	logic                  action_s1;
	logic [1:0]            phase_s1;
	logic [1:0]            last_phase_q;
	logic [COUNT_BITS-1:0] position_q;
	logic [COUNT_BITS-1:0] pos_tick_q;
	logic [COUNT_BITS-1:0] pos_next;
	dir_t                  dir;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (en && take) begin
			action_s1 <= action;
			phase_s1  <= {phase_a, phase_b};
		end
	end

	// step decode and next count
	always_comb begin
		dir      = step_dir({last_phase_q, phase_s1});
		pos_next = position_q;
		if (action_s1 == ACT_SAMPLE) begin
			case (dir)
				DIR_UP:   pos_next = position_q + COUNT_BITS'(1);
				DIR_DOWN: pos_next = position_q - COUNT_BITS'(1);
				default:  pos_next = position_q;
			endcase
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_phase_q <= '0;
			position_q   <= '0;
			pos_tick_q   <= '0;
		end else if (en && valid_s1) begin
			if (action_s1 == ACT_SAMPLE) begin
				last_phase_q <= phase_s1;
				position_q   <= pos_next;
			end else begin
				pos_tick_q <= position_q;
			end
		end
	end

	// stage 2 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			delta_s2.tick <= (action_s1 == ACT_TICK);
			delta_s2.diff <= position_q - pos_tick_q;
			delta_s2.pos  <= pos_next;
		end
	end

endmodule

### rtl/core/qdv_speed.sv
// qdv_speed: magnitude, Q16 scaling and saturation of the count change;
// holds the velocity state and the result register. Depends on qdv_pkg.
module qdv_speed
	import qdv_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         valid_s2,
	input  qdv_delta_t                   delta_s2,
	input  logic [SCALE_BITS-1:0]        scale,
	output logic                         out_valid_q,
	output logic signed [SPEED_BITS-1:0] velocity_q,
	output logic [COUNT_BITS-1:0]        position_q
);

	localparam logic [COUNT_BITS-1:0] LIM_POS = COUNT_BITS'((64'd1 << (SPEED_BITS - 1)) - 64'd1);
	localparam logic [COUNT_BITS-1:0] LIM_NEG = COUNT_BITS'(64'd1 << (SPEED_BITS - 1));

	logic                  valid_s3;
	logic                  valid_s4;
	qdv_mag_t              mag_s3;
	qdv_prod_t             prod_s4;
	logic [COUNT_BITS-1:0] quot;
	logic [COUNT_BITS-1:0] lim;
	logic [COUNT_BITS-1:0] sat;
	logic [SPEED_BITS-1:0] vel_new;

	// valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	// stage 3: sign and magnitude
	always_ff @(posedge clk) begin
		if (en && valid_s2) begin
			mag_s3.tick <= delta_s2.tick;
			mag_s3.neg  <= delta_s2.diff[COUNT_BITS-1];
			mag_s3.mag  <= delta_s2.diff[COUNT_BITS-1] ? (COUNT_BITS'(0) - delta_s2.diff)
				: delta_s2.diff;
			mag_s3.pos  <= delta_s2.pos;
		end
	end

	// stage 4: scale multiply
	always_ff @(posedge clk) begin
		if (en && valid_s3) begin
			prod_s4.tick <= mag_s3.tick;
			prod_s4.neg  <= mag_s3.neg;
			prod_s4.prod <= PROD_BITS'(mag_s3.mag) * PROD_BITS'(scale);
			prod_s4.pos  <= mag_s3.pos;
		end
	end

	// drop the Q16 fraction and clamp
	always_comb begin
		quot    = prod_s4.prod[PROD_BITS-1:SCALE_BITS];
		lim     = prod_s4.neg ? LIM_NEG : LIM_POS;
		sat     = (quot > lim) ? lim : quot;
		vel_new = prod_s4.neg ? (SPEED_BITS'(0) - sat[SPEED_BITS-1:0]) : sat[SPEED_BITS-1:0];
	end

	// velocity state doubles as the result velocity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			velocity_q <= '0;
		end else if (en && valid_s4 && prod_s4.tick) begin
			velocity_q <= vel_new;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s4) begin
			position_q <= prod_s4.pos;
		end
	end

endmodule

### rtl/core/quadrature_decoder_velocity.sv
// Quadrature x4 decoder with tick-based velocity.
//
// Channels: sample (sink) takes transactions carrying action, phase_a and
// phase_b; action 0 is a phase sample, action 1 a timer tick. result
// (source) gives one transaction per sample transaction: the latest
// velocity in mm/s and the signed position count after that item.
// cfg_we/cfg_wdata write the Q16 velocity scale; write only while idle.
//
// Throughput: one transaction per cycle while the result register is free
// or being taken. A sample passes the input register, change register,
// magnitude register, product register, then the result register. The
// path is set by the 32x16 scale multiplier, which has a stage of its own.
//
// Reset clears the position, the tick snapshot, the stored phase and the
// velocity to zero and loads the scale with 11932. When the receiver
// stalls with a result waiting, the whole pipeline holds and sample.ready
// drops in the same cycle; nothing is lost or repeated.
//
// Depends on qdv_pkg, qdv_if, qdv_decode and qdv_speed.
module quadrature_decoder_velocity
	import qdv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	qdv_sample_if.sink            sample,
	qdv_result_if.source          result,
	input  logic                  cfg_we,
	input  logic [SCALE_BITS-1:0] cfg_wdata
);

	logic                         en;
	logic                         take;
	logic                         valid_s2;
	qdv_delta_t                   delta_s2;
	logic [SCALE_BITS-1:0]        scale_q;
	logic                         out_valid;
	logic signed [SPEED_BITS-1:0] velocity;
	logic [COUNT_BITS-1:0]        position;

	// pipeline moves whenever the result register is free or being taken
	assign en           = !out_valid || result.ready;
	assign sample.ready = en;
	assign take         = sample.valid && en;

	// scale register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (cfg_we) begin
			scale_q <= cfg_wdata;
		end
	end

	qdv_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.take     (take),
		.action   (sample.action),
		.phase_a  (sample.phase_a),
		.phase_b  (sample.phase_b),
		.valid_s2 (valid_s2),
		.delta_s2 (delta_s2)
	);

	qdv_speed u_speed (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.valid_s2    (valid_s2),
		.delta_s2    (delta_s2),
		.scale       (scale_q),
		.out_valid_q (out_valid),
		.velocity_q  (velocity),
		.position_q  (position)
	);

	// sign-extend or cut to the port widths
	assign result.valid          = out_valid;
	assign result.velocity_mm_s  = VEL_OUT_BITS'(signed'(velocity));
	assign result.position_count = POS_OUT_BITS'(signed'(position));

endmodule

### rtl/core/qdv_checker.sv
// qdv_port_props: port-level checks on the quadrature decoder, bound to the
// top level. Depends on qdv_pkg for widths.
module qdv_port_props
	import qdv_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_ready,
	input  logic                    r_valid,
	input  logic                    r_ready,
	input  logic [POS_OUT_BITS-1:0] r_pos
);

	logic                    r_acc;
	logic                    acc_prev_q;
	logic [POS_OUT_BITS-1:0] pos_prev_q;
	logic [POS_OUT_BITS-1:0] pos_step;

	assign r_acc    = r_valid && r_ready;
	assign pos_step = r_pos - pos_prev_q;

	// last delivered position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_prev_q <= 1'b0;
		end else begin
			acc_prev_q <= r_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (r_acc) begin
			pos_prev_q <= r_pos;
		end
	end

	// a result waiting for the receiver stays offered
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid)
		else $error("result withdrawn while stalled");

	// with the result register empty the block takes a transaction
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!r_valid |-> s_ready)
		else $error("sample not ready with empty result register");

	// back-to-back results differ by at most one count
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		r_acc && acc_prev_q |-> (pos_step == POS_OUT_BITS'(0)) ||
			(pos_step == POS_OUT_BITS'(1)) || (pos_step == {POS_OUT_BITS{1'b1}}))
		else $error("position jumped by more than one count");

	// a stalled result cannot let a new transaction in
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |-> !s_ready)
		else $error("sample taken while result stalled");

endmodule

bind quadrature_decoder_velocity qdv_port_props u_qdv_port_props (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_ready (sample.ready),
	.r_valid (result.valid),
	.r_ready (result.ready),
	.r_pos   (result.position_count)
);
